// ----- sv/brrs_pkg.sv -----
// Package for the budgeted round-robin scheduler.
// Holds the operation and status codes, controller states, reset values and cell control type.
// No dependencies; brrs_cell and the top level import it.
`default_nettype none
package brrs_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_TIME   = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_RESUME = 3'd3,
        OP_REPORT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_RUN    = 2'd2,
        ST_FLOOR_HIT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    localparam logic [15:0] RATE_RESET     = 16'd256;
    localparam logic [22:0] CAPACITY_RESET = 23'd10000;
    localparam logic [17:0] ONE_TICK_Q8    = 18'd256;
    localparam logic signed [31:0] CREDIT_RESET = 32'sd2560000;
    localparam logic signed [31:0] CREDIT_FLOOR = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- sv/brrs_item_if.sv -----
// Input channel of the budgeted round-robin scheduler: valid/ready and one input word.
// No dependencies.
`default_nettype none
interface brrs_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  task_id;
    logic [15:0] elapsed;
    logic        keep;

    modport source (output valid, output op, output task_id, output elapsed, output keep,
                    input ready);
    modport sink (input valid, input op, input task_id, input elapsed, input keep,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/brrs_result_if.sv -----
// Result channel of the budgeted round-robin scheduler: valid/ready and one result word.
// No dependencies.
`default_nettype none
interface brrs_result_if;
    logic               valid;
    logic               ready;
    logic               grant;
    logic [7:0]         granted_task;
    logic [1:0]         status;
    logic [4:0]         tasks_held;
    logic signed [31:0] credit;

    modport source (output valid, output grant, output granted_task, output status,
                    output tasks_held, output credit, input ready);
    modport sink (input valid, input grant, input granted_task, input status,
                  input tasks_held, input credit, output ready);
endinterface
`default_nettype wire

// ----- sv/brrs_cell.sv -----
// One entry of the task list chain: loads a new task identifier or takes its neighbor's entry.
// Depends on brrs_pkg for the cell control type.
`default_nettype none
module brrs_cell
    import brrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic [7:0] i_task_id,
    input  wire logic [7:0] i_neighbor,
    output logic [7:0]     o_entry
);

    logic [7:0] r_entry;
    logic [7:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_task_id;
        end else if (i_ctl.shift) begin
            n_entry = i_neighbor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ----- sv/budgeted_round_robin_scheduler_unit.sv -----
// Top level of the budgeted round-robin scheduler: controller, credit datapath and task cell chain.
// Depends on brrs_pkg, brrs_item_if, brrs_result_if and brrs_cell.
//
//   channel   direction  fields
//   i_item    in         op, task_id, elapsed, keep
//   o_result  out        grant, granted_task, status, tasks_held, credit
//   i_cfg_*   in         credit_rate (index 0), credit_capacity (index 1)
//
// Each word passes through three steps: accept with the rate product, state update, result load.
// The product register and the cell chain update set these steps.
// Reset is synchronous; no clearing pass is needed.
// A new word is accepted while a result still waits; the controller holds only when a
// second result is ready and the output register is still full.
`default_nettype none
module budgeted_round_robin_scheduler_unit
    import brrs_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    brrs_item_if.sink                  i_item,
    brrs_result_if.source              o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_TASKS);
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);

    t_state             r_state, n_state;
    logic [15:0]        r_rate;
    logic [22:0]        r_cap;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_credit, n_credit;
    logic               r_paused, n_paused;
    logic               r_running, n_running;

    logic [2:0]         r_op;
    logic [7:0]         r_id;
    logic               r_keep;
    logic signed [34:0] r_prod;
    logic [1:0]         r_status, n_status;

    logic               r_out_valid, n_out_valid;
    logic               r_grant, n_grant;
    logic [7:0]         r_who, n_who;
    logic [1:0]         r_out_status, n_out_status;
    logic [4:0]         r_held, n_held;
    logic signed [31:0] r_out_credit, n_out_credit;

    logic               w_accept;
    logic signed [17:0] w_rate;
    logic signed [34:0] w_prod;
    logic signed [35:0] w_sum;
    logic signed [35:0] w_cap;
    logic signed [35:0] w_floor;
    logic [CW-1:0]      w_pos_ext;
    logic [CW-1:0]      w_pos_inc;
    logic [CW-1:0]      w_cnt_dec;
    logic [CW+4:0]      w_cnt_wide;
    logic               w_add_ok;
    logic               w_remove;
    logic               w_grant;
    logic [7:0]         w_entry [MAX_TASKS];
    t_cell_ctl          w_ctl [MAX_TASKS];

    assign w_accept       = i_item.valid && i_item.ready;
    assign i_item.ready   = (r_state == S_IDLE);
    assign w_rate         = $signed({2'b00, r_rate}) - (r_running ? $signed(ONE_TICK_Q8) : 18'sd0);
    assign w_prod         = $signed({1'b0, i_item.elapsed}) * w_rate;
    assign w_pos_ext      = CW'(r_pos);
    assign w_pos_inc      = w_pos_ext + CW'(1);
    assign w_cnt_dec      = r_count - CW'(1);
    assign w_cnt_wide     = {5'b00000, r_count};
    assign w_cap          = $signed({5'b00000, r_cap, 8'h00});
    assign w_floor        = 36'(CREDIT_FLOOR);
    assign w_add_ok       = (r_state == S_EXEC) && (r_op == OP_ADD) && (r_count < CW'(MAX_TASKS));
    assign w_remove       = (r_state == S_EXEC) && (r_op == OP_REPORT) && r_running
                            && (r_count != '0) && (w_pos_ext < r_count) && !r_keep;
    assign w_grant        = !r_paused && (r_count != '0) && (r_credit > 32'sd0)
                            && (w_pos_ext < r_count);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            logic [7:0] w_next;
            if (gi == MAX_TASKS - 1) begin : g_last
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end
            assign w_ctl[gi].load  = w_add_ok && (r_count == CW'(gi));
            assign w_ctl[gi].shift = w_remove && (CW'(gi) >= w_pos_ext)
                                     && (CW'(gi + 1) < r_count);
            brrs_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[gi]),
                .i_task_id  (r_id),
                .i_neighbor (w_next),
                .o_entry    (w_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_credit     = r_credit;
        n_paused     = r_paused;
        n_running    = r_running;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_grant      = r_grant;
        n_who        = r_who;
        n_out_status = r_out_status;
        n_held       = r_held;
        n_out_credit = r_out_credit;
        w_sum        = 36'(r_credit) + 36'(r_prod);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_RESP;
                case (r_op)
                    OP_ADD: begin
                        if (w_add_ok) begin
                            if (r_count == '0) begin
                                n_pos = '0;
                            end
                            n_count = r_count + CW'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    OP_TIME: begin
                        if (!r_paused) begin
                            if (w_sum > w_cap) begin
                                w_sum = w_cap;
                            end
                            if (w_sum < w_floor) begin
                                n_credit = CREDIT_FLOOR;
                                n_status = ST_FLOOR_HIT;
                            end else begin
                                n_credit = w_sum[31:0];
                            end
                        end
                    end
                    OP_PAUSE: begin
                        n_paused = 1'b1;
                    end
                    OP_RESUME: begin
                        n_paused = 1'b0;
                    end
                    OP_REPORT: begin
                        if (!r_running || r_count == '0 || w_pos_ext >= r_count) begin
                            n_status = ST_NO_RUN;
                        end else if (r_keep) begin
                            n_pos = (w_pos_inc >= r_count) ? '0 : w_pos_inc[IW-1:0];
                        end else begin
                            n_count = w_cnt_dec;
                            if (w_pos_ext >= w_cnt_dec) begin
                                n_pos = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_grant      = w_grant;
                    n_who        = w_grant ? w_entry[r_pos] : 8'h00;
                    n_out_status = r_status;
                    n_held       = w_cnt_wide[4:0];
                    n_out_credit = r_credit;
                    n_running    = w_grant;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_cap       <= CAPACITY_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_credit    <= CREDIT_RESET;
            r_paused    <= 1'b1;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_credit    <= n_credit;
            r_paused    <= n_paused;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE: begin
                        r_rate <= i_cfg_data[15:0];
                    end
                    CFG_CAPACITY: begin
                        r_cap <= i_cfg_data[22:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_item.op;
            r_id   <= i_item.task_id;
            r_keep <= i_item.keep;
            r_prod <= w_prod;
        end
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_who        <= n_who;
        r_out_status <= n_out_status;
        r_held       <= n_held;
        r_out_credit <= n_out_credit;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.grant        = r_grant;
    assign o_result.granted_task = r_who;
    assign o_result.status       = r_out_status;
    assign o_result.tasks_held   = r_held;
    assign o_result.credit       = r_out_credit;

endmodule
`default_nettype wire
